// ----- hw/rtl/call_stack_latency_profiler_defines.svh -----
// assertion macros for the call stack latency profiler
`ifndef CALL_STACK_LATENCY_PROFILER_DEFINES_SVH
`define CALL_STACK_LATENCY_PROFILER_DEFINES_SVH

`ifndef SYNTHESIS

`define CSLP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cslp assertion failed");

`define CSLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cslp assertion failed");

`else

`define CSLP_ASSERT_IMPL(label, clk, rst, ante, cons)

`define CSLP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/cslp_pkg.sv -----
`timescale 1ns / 1ps

package cslp_pkg;

  localparam int STACK_DEPTH_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int TIME_W = 27;
  localparam int DEPTH_CFG_W = 7;
  localparam int REC_DEPTH_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [TIME_W-1:0] WRAP_US = TIME_W'(100000000);

  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 2'd2;

  localparam logic [TIME_W-1:0] MIN_COST_RESET = TIME_W'(1000);
  localparam logic [DEPTH_CFG_W-1:0] MAX_DEPTH_RESET = DEPTH_CFG_W'(3);

  localparam logic [2:0] ST_PUSHED = 3'd0;
  localparam logic [2:0] ST_POPPED = 3'd1;
  localparam logic [2:0] ST_POPPED_RECORD = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;
  localparam logic [1:0] KIND_UNDERFLOW = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [63:0] class_handle;
    logic [63:0] selector_handle;
    logic [63:0] return_address;
    logic [26:0] now_us;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] popped_return_address;
    logic        record_valid;
    logic [63:0] record_class;
    logic [63:0] record_selector;
    logic [5:0]  record_depth;
    logic [26:0] record_cost_us;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] class_handle;
    logic [63:0] selector_handle;
    logic [63:0] return_address;
    logic [26:0] now_us;
  } cmd_t;

  typedef struct packed {
    logic [63:0] class_handle;
    logic [63:0] selector_handle;
    logic [63:0] return_address;
    logic [26:0] start_us;
  } frame_t;

endpackage

// ----- hw/rtl/call_stack_latency_profiler.sv -----
`timescale 1ns / 1ps
// channel   signals                     direction  word
// req       req_valid req_ready req     in         opcode, handles, return address, time
// rsp       rsp_valid rsp_ready rsp     out        status, popped address, record
// cfg       cfg_we cfg_index cfg_data   in         register write, no handshake
//
// a call or a fault word is answered from the idle state, a return passes three steps:
// frame memory read, elapsed time, record check
// reset empties the stack and loads the register defaults, no clearing pass
// a two-word queue between classifier and back end absorbs result stalls

`include "call_stack_latency_profiler_defines.svh"

module call_stack_latency_profiler #(
  parameter int STACK_DEPTH = cslp_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cslp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cslp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  cslp_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output cslp_pkg::rsp_t                  rsp
);

  logic           fq_valid;
  logic           fq_ready;
  cslp_pkg::cmd_t fq_cmd;
  logic           qb_valid;
  logic           qb_ready;
  cslp_pkg::cmd_t qb_cmd;

  logic           rsp_is_record;
  logic           rsp_is_nonpop;
  logic           rsp_nonpop_zero;
  logic           rsp_known;
  logic           qb_nonpop_take;

  cslp_front #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  cslp_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_cmd)
  );

  cslp_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign rsp_is_record = (rsp.status == cslp_pkg::ST_POPPED_RECORD);
  assign rsp_is_nonpop = (rsp.status == cslp_pkg::ST_PUSHED)
                         || (rsp.status == cslp_pkg::ST_OVERFLOW)
                         || (rsp.status == cslp_pkg::ST_UNDERFLOW);
  assign rsp_nonpop_zero = (rsp.popped_return_address == '0) && !rsp.record_valid;
  assign rsp_known = rsp_is_nonpop || rsp_is_record || (rsp.status == cslp_pkg::ST_POPPED);
  assign qb_nonpop_take = qb_valid && qb_ready && (qb_cmd.kind != cslp_pkg::KIND_POP);

  `CSLP_ASSERT_IMPL(a_record_status, clk, rst, rsp_valid, rsp.record_valid == rsp_is_record)
  `CSLP_ASSERT_IMPL(a_nonpop_clean, clk, rst, rsp_valid && rsp_is_nonpop, rsp_nonpop_zero)
  `CSLP_ASSERT_IMPL(a_status_range, clk, rst, rsp_valid, rsp_known)
  `CSLP_ASSERT_NEXT(a_queue_drains, clk, rst, qb_nonpop_take && !fq_valid, !rsp_valid || !rsp_is_record)

endmodule

// ----- hw/rtl/cslp_front.sv -----
`timescale 1ns / 1ps

module cslp_front #(
  parameter int STACK_DEPTH = cslp_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  cslp_pkg::req_t req,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output cslp_pkg::cmd_t cmd
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             full;
  logic             empty;

  assign full = (count == CNT_W'(STACK_DEPTH));
  assign empty = (count == '0);

  assign req_ready = cmd_ready;
  assign cmd_valid = req_valid;

  // classify against the speculative depth
  always_comb begin
    cmd.class_handle = req.class_handle;
    cmd.selector_handle = req.selector_handle;
    cmd.return_address = req.return_address;
    cmd.now_us = req.now_us;
    count_next = count;
    if (!req.opcode) begin
      if (full) begin
        cmd.kind = cslp_pkg::KIND_OVERFLOW;
      end else begin
        cmd.kind = cslp_pkg::KIND_PUSH;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        cmd.kind = cslp_pkg::KIND_UNDERFLOW;
      end else begin
        cmd.kind = cslp_pkg::KIND_POP;
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req_valid && cmd_ready) begin
      count <= count_next;
    end
  end

endmodule

// ----- hw/rtl/cslp_fifo.sv -----
`timescale 1ns / 1ps

module cslp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  cslp_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output cslp_pkg::cmd_t rd_data
);

  localparam int DEPTH = cslp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cslp_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (fill != CNT_W'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data = slots[rd_ptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/cslp_back.sv -----
`timescale 1ns / 1ps

module cslp_back #(
  parameter int STACK_DEPTH = cslp_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cslp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cslp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  cslp_pkg::cmd_t                      cmd,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output cslp_pkg::rsp_t                      rsp
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CMP_W = (IDX_W > cslp_pkg::DEPTH_CFG_W) ? IDX_W : cslp_pkg::DEPTH_CFG_W;

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_READ = 2'd1;
  localparam logic [1:0] BK_EVAL = 2'd2;

  cslp_pkg::frame_t mem [STACK_DEPTH];

  logic [1:0]                          state;
  logic [CNT_W-1:0]                    count;
  logic [IDX_W-1:0]                    pop_idx;
  logic [IDX_W-1:0]                    top_idx;
  logic [cslp_pkg::TIME_W-1:0]         now_us;
  logic [cslp_pkg::TIME_W-1:0]         cost;
  cslp_pkg::frame_t                    frame;

  logic                                record_enable;
  logic [cslp_pkg::TIME_W-1:0]         min_cost_us;
  logic [cslp_pkg::DEPTH_CFG_W-1:0]    max_record_depth;

  logic                                rsp_free;
  logic                                take;
  logic                                rsp_set;
  logic [cslp_pkg::TIME_W-1:0]         cost_next;
  logic                                hit;

  assign rsp_free = !rsp_valid || rsp_ready;
  assign cmd_ready = (state == BK_IDLE) && rsp_free;
  assign take = cmd_valid && cmd_ready;
  assign top_idx = IDX_W'(count - CNT_W'(1));
  assign rsp_set = (take && cmd.kind != cslp_pkg::KIND_POP) || (state == BK_EVAL && rsp_free);

  // elapsed time with one wrap when the clock went backwards
  assign cost_next = (now_us < frame.start_us) ? (now_us + cslp_pkg::WRAP_US - frame.start_us)
                                               : (now_us - frame.start_us);

  assign hit = record_enable && (cost > min_cost_us)
               && (CMP_W'(pop_idx) <= CMP_W'(max_record_depth));

  always_ff @(posedge clk) begin
    if (rst) begin
      record_enable <= 1'b1;
      min_cost_us <= cslp_pkg::MIN_COST_RESET;
      max_record_depth <= cslp_pkg::MAX_DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cslp_pkg::CFG_RECORD_ENABLE: record_enable <= cfg_data[0];
        cslp_pkg::CFG_MIN_COST:      min_cost_us <= cfg_data[cslp_pkg::TIME_W-1:0];
        cslp_pkg::CFG_MAX_DEPTH:     max_record_depth <= cfg_data[cslp_pkg::DEPTH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // frame memory
  always_ff @(posedge clk) begin
    if (take && cmd.kind == cslp_pkg::KIND_PUSH) begin
      mem[count[IDX_W-1:0]] <= '{class_handle:    cmd.class_handle,
                                 selector_handle: cmd.selector_handle,
                                 return_address:  cmd.return_address,
                                 start_us:        cmd.now_us};
    end
    if (take && cmd.kind == cslp_pkg::KIND_POP) begin
      frame <= mem[top_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == cslp_pkg::KIND_POP) begin
      pop_idx <= top_idx;
      now_us <= cmd.now_us;
    end
    if (state == BK_READ) begin
      cost <= cost_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_set) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        BK_IDLE: begin
          if (take) begin
            unique case (cmd.kind)
              cslp_pkg::KIND_PUSH: begin
                count <= count + CNT_W'(1);
              end
              cslp_pkg::KIND_POP: begin
                count <= count - CNT_W'(1);
                state <= BK_READ;
              end
              default: ;
            endcase
          end
        end
        BK_READ: begin
          state <= BK_EVAL;
        end
        BK_EVAL: begin
          if (rsp_free) begin
            state <= BK_IDLE;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (take && cmd.kind != cslp_pkg::KIND_POP) begin
      unique case (cmd.kind)
        cslp_pkg::KIND_PUSH:     rsp <= '{status: cslp_pkg::ST_PUSHED, default: '0};
        cslp_pkg::KIND_OVERFLOW: rsp <= '{status: cslp_pkg::ST_OVERFLOW, default: '0};
        default:                 rsp <= '{status: cslp_pkg::ST_UNDERFLOW, default: '0};
      endcase
    end else if (state == BK_EVAL && rsp_free) begin
      rsp.popped_return_address <= frame.return_address;
      if (hit) begin
        rsp.status <= cslp_pkg::ST_POPPED_RECORD;
        rsp.record_valid <= 1'b1;
        rsp.record_class <= frame.class_handle;
        rsp.record_selector <= frame.selector_handle;
        rsp.record_depth <= cslp_pkg::REC_DEPTH_W'(pop_idx);
        rsp.record_cost_us <= cost;
      end else begin
        rsp.status <= cslp_pkg::ST_POPPED;
        rsp.record_valid <= 1'b0;
        rsp.record_class <= '0;
        rsp.record_selector <= '0;
        rsp.record_depth <= '0;
        rsp.record_cost_us <= '0;
      end
    end
  end

endmodule

// ----- bench/call_stack_latency_profiler_tb.sv -----
`timescale 1ns / 1ps

module call_stack_latency_profiler_tb;

  localparam int STACK_DEPTH = cslp_pkg::STACK_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic OP_CALL = 1'b0;
  localparam logic OP_RETURN = 1'b1;
  localparam logic [cslp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [cslp_pkg::TIME_W-1:0] TIME_MAX = '1;
  localparam int unsigned WRAP = 100000000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [cslp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cslp_pkg::CFG_DATA_W-1:0] cfg_data;
  logic req_valid;
  logic req_ready;
  cslp_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  cslp_pkg::rsp_t rsp;

  call_stack_latency_profiler dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  // shadow copy of the stack and registers
  logic [63:0] shadow_class [STACK_DEPTH];
  logic [63:0] shadow_selector [STACK_DEPTH];
  logic [63:0] shadow_return [STACK_DEPTH];
  logic [cslp_pkg::TIME_W-1:0] shadow_start [STACK_DEPTH];
  int frames_held = 0;
  logic record_on = 1'b1;
  logic [cslp_pkg::TIME_W-1:0] min_cost = cslp_pkg::MIN_COST_RESET;
  logic [cslp_pkg::DEPTH_CFG_W-1:0] max_depth = cslp_pkg::MAX_DEPTH_RESET;

  cslp_pkg::rsp_t predicted_results[$];
  int errors = 0;
  int cycle_count = 0;
  bit pace_on = 1'b0;
  int unsigned wall_us = 0;

  function automatic cslp_pkg::rsp_t step_shadow_stack(cslp_pkg::req_t w);
    cslp_pkg::rsp_t r;
    int top;
    logic [63:0] t;
    logic [63:0] cost;
    r = '0;
    if (w.opcode == OP_CALL) begin
      if (frames_held >= STACK_DEPTH) begin
        r.status = cslp_pkg::ST_OVERFLOW;
      end else begin
        shadow_class[frames_held] = w.class_handle;
        shadow_selector[frames_held] = w.selector_handle;
        shadow_return[frames_held] = w.return_address;
        shadow_start[frames_held] = w.now_us;
        frames_held++;
        r.status = cslp_pkg::ST_PUSHED;
      end
    end else if (frames_held == 0) begin
      r.status = cslp_pkg::ST_UNDERFLOW;
    end else begin
      top = frames_held - 1;
      r.status = cslp_pkg::ST_POPPED;
      r.popped_return_address = shadow_return[top];
      if (record_on) begin
        t = 64'(w.now_us);
        if (t < 64'(shadow_start[top])) t = t + 64'(cslp_pkg::WRAP_US);
        cost = (t - 64'(shadow_start[top])) & 64'(TIME_MAX);
        if (cost > 64'(min_cost) && top <= int'(max_depth)) begin
          r.status = cslp_pkg::ST_POPPED_RECORD;
          r.record_valid = 1'b1;
          r.record_class = shadow_class[top];
          r.record_selector = shadow_selector[top];
          r.record_depth = top[cslp_pkg::REC_DEPTH_W-1:0];
          r.record_cost_us = cost[cslp_pkg::TIME_W-1:0];
        end
      end
      frames_held = top;
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic cslp_pkg::req_t make_word(logic op, logic [63:0] c, logic [63:0] s,
                                               logic [63:0] r,
                                               logic [cslp_pkg::TIME_W-1:0] now);
    cslp_pkg::req_t w;
    w.opcode = op;
    w.class_handle = c;
    w.selector_handle = s;
    w.return_address = r;
    w.now_us = now;
    return w;
  endfunction

  function automatic cslp_pkg::req_t random_word(logic op, logic [cslp_pkg::TIME_W-1:0] now);
    return make_word(op, rand64(), rand64(), rand64(), now);
  endfunction

  // mostly steps around the cost threshold, with wraps, jumps and out-of-range times
  function automatic logic [cslp_pkg::TIME_W-1:0] advance_clock();
    int unsigned pick;
    int unsigned step;
    pick = $urandom_range(0, 15);
    if (pick == 0) return cslp_pkg::TIME_W'($urandom);
    if (pick == 1) begin
      wall_us = $urandom_range(WRAP, 32'(TIME_MAX));
      return cslp_pkg::TIME_W'(wall_us);
    end
    if (pick <= 5) step = $urandom_range(0, 2000);
    else if (pick <= 13) step = $urandom_range(0, 2 * int'(min_cost) + 4);
    else if (pick == 14) step = $urandom_range(0, WRAP - 1);
    else step = 0;
    wall_us = (wall_us + step) % WRAP;
    return cslp_pkg::TIME_W'(wall_us);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic send_word(cslp_pkg::req_t w);
    if (pace_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    predicted_results.push_back(step_shadow_stack(w));
    @(posedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [cslp_pkg::CFG_IDX_W-1:0] idx,
                           logic [cslp_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      cslp_pkg::CFG_RECORD_ENABLE: record_on = data[0];
      cslp_pkg::CFG_MIN_COST: min_cost = data;
      cslp_pkg::CFG_MAX_DEPTH: max_depth = data[cslp_pkg::DEPTH_CFG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_edges();
    int k;
    send_word(random_word(OP_RETURN, 5));
    send_word(make_word(OP_CALL, '0, '0, '0, '0));
    send_word(random_word(OP_RETURN, 1000));
    send_word(make_word(OP_CALL, '1, '1, '1, 99999000));
    send_word(random_word(OP_RETURN, 1));
    send_word(random_word(OP_CALL, TIME_MAX));
    send_word(random_word(OP_RETURN, '0));
    for (k = 0; k < 5; k++) send_word(random_word(OP_CALL, cslp_pkg::TIME_W'(10 * k)));
    send_word(random_word(OP_RETURN, 100000));
    for (k = 0; k < 4; k++) send_word(random_word(OP_RETURN, cslp_pkg::TIME_W'(200000 + k)));
    send_word(random_word(OP_RETURN, 300000));
  endtask

  task automatic test_register_writes();
    settle();
    write_reg(CFG_UNUSED, cslp_pkg::TIME_W'($urandom));
    send_word(random_word(OP_CALL, 0));
    send_word(random_word(OP_RETURN, 5000));
    settle();
    write_reg(cslp_pkg::CFG_RECORD_ENABLE, '0);
    send_word(random_word(OP_CALL, 0));
    send_word(random_word(OP_RETURN, 50000));
    // start time is kept while recording is off
    send_word(random_word(OP_CALL, 100));
    settle();
    write_reg(cslp_pkg::CFG_RECORD_ENABLE, 27'd1);
    send_word(random_word(OP_RETURN, 200000));
    settle();
    write_reg(cslp_pkg::CFG_MIN_COST, '0);
    write_reg(cslp_pkg::CFG_MAX_DEPTH, '0);
    send_word(random_word(OP_CALL, 7));
    send_word(random_word(OP_RETURN, 7));
    send_word(random_word(OP_CALL, 7));
    send_word(random_word(OP_RETURN, 8));
    settle();
    write_reg(cslp_pkg::CFG_MIN_COST, TIME_MAX);
    write_reg(cslp_pkg::CFG_MAX_DEPTH, 27'd127);
    send_word(random_word(OP_CALL, 50));
    send_word(random_word(OP_RETURN, 49));
  endtask

  task automatic test_full_stack();
    int k;
    settle();
    write_reg(cslp_pkg::CFG_MIN_COST, '0);
    write_reg(cslp_pkg::CFG_MAX_DEPTH, 27'd64);
    for (k = 0; k < STACK_DEPTH + 3; k++) send_word(random_word(OP_CALL, advance_clock()));
    for (k = 0; k < STACK_DEPTH + 2; k++) send_word(random_word(OP_RETURN, advance_clock()));
  endtask

  task automatic run_phase(int items, int push_pct, bit paced, logic en,
                           logic [cslp_pkg::TIME_W-1:0] cost_floor,
                           logic [cslp_pkg::DEPTH_CFG_W-1:0] depth_cap);
    int k;
    logic op;
    settle();
    pace_on = paced;
    write_reg(cslp_pkg::CFG_RECORD_ENABLE,
              {cslp_pkg::TIME_W'($urandom) & ~cslp_pkg::TIME_W'(1)} | cslp_pkg::TIME_W'(en));
    write_reg(cslp_pkg::CFG_MIN_COST, cost_floor);
    write_reg(cslp_pkg::CFG_MAX_DEPTH, {20'($urandom), depth_cap});
    for (k = 0; k < items; k++) begin
      op = ($urandom_range(0, 99) < push_pct) ? OP_CALL : OP_RETURN;
      send_word(random_word(op, advance_clock()));
    end
  endtask

  task automatic test_random_stacks();
    run_phase(220, 50, $urandom_range(0, 3) != 0, 1'b1, 1000, 3);
    run_phase(220, 60, $urandom_range(0, 3) != 0, 1'b1, 0, 64);
    run_phase(220, 85, $urandom_range(0, 3) != 0, 1'b1, 500, 127);
    run_phase(220, 20, $urandom_range(0, 3) != 0, 1'b0, 5000, 64);
    run_phase(220, 55, $urandom_range(0, 3) != 0, 1'b1, 99999999, 127);
    run_phase(220, 50, $urandom_range(0, 3) != 0, 1'b1,
              cslp_pkg::TIME_W'($urandom_range(0, 5000)),
              cslp_pkg::DEPTH_CFG_W'($urandom_range(0, 70)));
  endtask

  task automatic test_back_to_back();
    run_phase(150, 55, 1'b0, 1'b1, 2000, 64);
  endtask

  always begin
    @(posedge clk);
    if (pace_on && $urandom_range(0, 4) == 0) begin
      rsp_ready <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    rsp_ready <= 1'b1;
  end

  always @(negedge clk) begin : check_result
    cslp_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h", $time, rsp);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        check_field("status", 64'(want.status), 64'(rsp.status));
        check_field("popped_return_address", want.popped_return_address,
                    rsp.popped_return_address);
        check_field("record_valid", 64'(want.record_valid), 64'(rsp.record_valid));
        check_field("record_class", want.record_class, rsp.record_class);
        check_field("record_selector", want.record_selector, rsp.record_selector);
        check_field("record_depth", 64'(want.record_depth), 64'(rsp.record_depth));
        check_field("record_cost_us", 64'(want.record_cost_us), 64'(rsp.record_cost_us));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** call_stack_latency_profiler: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = cslp_pkg::CFG_RECORD_ENABLE;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    pace_on = 1'b1;
    test_directed_edges();
    test_register_writes();
    test_full_stack();
    test_random_stacks();
    test_back_to_back();
    settle();
    if (errors == 0) begin
      $display("** call_stack_latency_profiler: PASSED **");
    end else begin
      $display("** call_stack_latency_profiler: FAILED **");
    end
    $finish;
  end

endmodule
